FILE: rtl/rm_pkg.sv
package rm_pkg;

    localparam int CAPACITY   = 64;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 7;
    localparam int HELD_W     = $clog2(CAPACITY + 1);
    localparam int GROUP_SIZE = 8;
    localparam int NGROUPS    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median_value;
        logic [COUNT_W-1:0]         sample_count;
        logic                       dropped;
    } out_item_t;

    // what one cell hands to its upper neighbour
    typedef struct packed {
        logic                       gt;
        logic signed [SAMPLE_W-1:0] value;
    } link_t;

endpackage

FILE: rtl/rm_cell.sv
module rm_cell
    import rm_pkg::*;
(
    input  logic                       clk,
    input  logic                       load,
    input  logic                       occupied,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  link_t                      lower,
    output link_t                      upper
);

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       gt;

    // an empty cell acts as plus infinity
    assign gt = !occupied || (value_reg > sample);

    always_comb
    begin
        if (lower.gt)
        begin
            value_next = lower.value;
        end
        else if (gt)
        begin
            value_next = sample;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign upper.gt    = gt;
    assign upper.value = value_reg;

endmodule

FILE: rtl/rm_median.sv
module rm_median
    import rm_pkg::*;
(
    input  logic                       clk,
    input  logic                       capture,
    input  logic [HELD_W-1:0]          held_count,
    input  logic signed [SAMPLE_W-1:0] cell_values [CAPACITY],
    output logic signed [SAMPLE_W-1:0] median
);

    logic [SAMPLE_W-1:0] grp_lo_reg  [NGROUPS];
    logic [SAMPLE_W-1:0] grp_hi_reg  [NGROUPS];
    logic [SAMPLE_W-1:0] grp_lo_next [NGROUPS];
    logic [SAMPLE_W-1:0] grp_hi_next [NGROUPS];
    logic [HELD_W-1:0]   lo_pos;
    logic [HELD_W-1:0]   hi_pos;
    logic                nonempty;
    logic [SAMPLE_W-1:0] lo_val;
    logic [SAMPLE_W-1:0] hi_val;
    logic signed [SAMPLE_W:0] sum;
    logic signed [SAMPLE_W:0] sum_adj;

    // lower and upper middle positions, equal for an odd count
    assign nonempty = (held_count != '0);
    assign lo_pos   = (held_count - HELD_W'(1)) >> 1;
    assign hi_pos   = held_count >> 1;

    // first tree level: pick the middle cells within each group
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            grp_lo_next[g] = '0;
            grp_hi_next[g] = '0;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (nonempty && (HELD_W'(i) == lo_pos))
            begin
                grp_lo_next[i / GROUP_SIZE] = grp_lo_next[i / GROUP_SIZE] | cell_values[i];
            end
            if (nonempty && (HELD_W'(i) == hi_pos))
            begin
                grp_hi_next[i / GROUP_SIZE] = grp_hi_next[i / GROUP_SIZE] | cell_values[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            grp_lo_reg <= grp_lo_next;
            grp_hi_reg <= grp_hi_next;
        end
    end

    // second level, then average truncated toward zero
    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            lo_val = lo_val | grp_lo_reg[g];
            hi_val = hi_val | grp_hi_reg[g];
        end
    end

    assign sum     = $signed({lo_val[SAMPLE_W-1], lo_val}) + $signed({hi_val[SAMPLE_W-1], hi_val});
    assign sum_adj = (sum[SAMPLE_W] && sum[0]) ? (sum + (SAMPLE_W+1)'(1)) : sum;
    assign median  = sum_adj[SAMPLE_W:1];

endmodule

FILE: rtl/running_median.sv
// running median of a signed 16-bit sample stream. every input transfer gives
// exactly one result transfer: the median of all samples held since the last
// clear, the number held, and a flag that is set when a sample is dropped
// because CAPACITY samples are already held. an even count gives the mean of
// the two middle samples truncated toward zero; an empty store gives median 0.
// samples are kept sorted in a chain of CAPACITY cells that all shift together
// on insertion, and the middle cells are picked by a two-level registered
// selection tree. an item passes from input transfer to result through
// insertion into the chain, the first tree level, then the second level with
// the averaging add. a new item is taken at the earliest in the cycle its
// predecessor's result is transferred, so items never overlap in the block.
// no clearing pass is needed after reset
module running_median
    import rm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    input  in_item_t  sample_item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_item
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_GATHER = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [HELD_W-1:0]   held_count_reg;
    logic [HELD_W-1:0]   held_count_next;
    logic                dropped_reg;
    logic                dropped_next;
    out_item_t           result_reg;
    logic                accept;
    logic                full;
    logic                load;
    link_t               links [CAPACITY+1];
    logic signed [SAMPLE_W-1:0] cell_values [CAPACITY];
    logic signed [SAMPLE_W-1:0] median;

    // a new transfer may be taken while the previous result leaves
    assign sample_ready = (state_reg == ST_IDLE) || ((state_reg == ST_HOLD) && result_ready);
    assign accept       = sample_valid && sample_ready;
    assign full         = (held_count_reg >= HELD_W'(CAPACITY));
    // chain shifts only for a sample that fits
    assign load         = accept && (sample_item.kind == KIND_SAMPLE) && !full;

    // bottom of the chain: nothing below cell 0 is greater
    assign links[0] = '{gt: 1'b0, value: '0};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        rm_cell u_cell (
            .clk      (clk),
            .load     (load),
            .occupied (HELD_W'(i) < held_count_reg),
            .sample   (sample_item.sample_value),
            .lower    (links[i]),
            .upper    (links[i+1])
        );
        assign cell_values[i] = links[i+1].value;
    end

    rm_median u_median (
        .clk         (clk),
        .capture     (state_reg == ST_GATHER),
        .held_count  (held_count_reg),
        .cell_values (cell_values),
        .median      (median)
    );

    // held count and drop flag settle at the input transfer
    always_comb
    begin
        held_count_next = held_count_reg;
        dropped_next    = dropped_reg;
        if (accept)
        begin
            priority if (sample_item.kind == KIND_CLEAR)
            begin
                held_count_next = '0;
                dropped_next    = 1'b0;
            end
            else if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                held_count_next = held_count_reg + HELD_W'(1);
                dropped_next    = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (accept)
                begin
                    state_next = ST_GATHER;
                end
                else if (result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            dropped_reg    <= dropped_next;
        end
    end

    // result register, loaded when the tree has finished
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REDUCE)
        begin
            result_reg.median_value <= median;
            result_reg.sample_count <= COUNT_W'(held_count_reg);
            result_reg.dropped      <= dropped_reg;
        end
    end

    assign result_valid = (state_reg == ST_HOLD);
    assign result_item  = result_reg;

`ifndef SYNTHESIS
    // store never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= HELD_W'(CAPACITY))
        else $error("held count above capacity");

    // a clear transfer empties the store
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sample_item.kind == KIND_CLEAR)) |=> (held_count_reg == '0))
        else $error("clear did not empty the store");

    // a stored sample grows the count by one
    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (held_count_reg == $past(held_count_reg) + HELD_W'(1)))
        else $error("insertion did not grow the count");

    // a drop is only flagged with a full store
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> (held_count_reg == HELD_W'(CAPACITY)))
        else $error("drop flagged below capacity");

    // every result is taken before the next item finishes
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE) |-> !result_valid)
        else $error("result overwritten before transfer");
`endif

endmodule

FILE: tb/tb_running_median.sv
module tb_running_median;
    import rm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // how the random sample values of one stream are spread
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EDGES
    } spread_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_ready;
    in_item_t  sample_item  = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result_item;

    // idling percentages, changed per test phase
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int error_count = 0;

    // own copy of the block's sorted sample store
    logic signed [SAMPLE_W-1:0] sorted_samples [CAPACITY];
    int unsigned                samples_held = 0;

    // medians still owed by the block, oldest first
    out_item_t pending_medians [$];

    running_median dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always #5 clk = ~clk;

    // apply one accepted input to the store copy and give the result it should cause
    function automatic out_item_t update_median(input in_item_t item);
        out_item_t                  res;
        logic signed [SAMPLE_W-1:0] value;
        int                         pos;
        int                         mid;
        int                         pair_sum;
        value       = item.sample_value;
        res.dropped = 1'b0;
        if (item.kind == KIND_CLEAR)
        begin
            samples_held = 0;
        end
        else if (samples_held >= CAPACITY)
        begin
            // store full: sample is lost, store unchanged
            res.dropped = 1'b1;
        end
        else
        begin
            // insertion after any equal samples
            pos = samples_held;
            while (pos > 0 && sorted_samples[pos - 1] > value)
            begin
                sorted_samples[pos] = sorted_samples[pos - 1];
                pos--;
            end
            sorted_samples[pos] = value;
            samples_held++;
        end
        if (samples_held == 0)
        begin
            res.median_value = '0;
        end
        else
        begin
            mid = samples_held / 2;
            if (samples_held % 2 == 1)
            begin
                res.median_value = sorted_samples[mid];
            end
            else
            begin
                // integer division truncates toward zero, as required
                pair_sum = int'(sorted_samples[mid - 1]) + int'(sorted_samples[mid]);
                res.median_value = SAMPLE_W'(pair_sum / 2);
            end
        end
        res.sample_count = COUNT_W'(samples_held);
        return res;
    endfunction

    // receiver side: result_ready has this one driver, one update per edge
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // both transfer points sampled at the edge; the result side is checked before
    // the input side is predicted, since a result never belongs to a same-edge input
    always @(posedge clk)
    begin : transfer_monitor
        out_item_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_medians.size() == 0)
                begin
                    $error("unexpected result transfer: median %0d count %0d dropped %0d",
                           result_item.median_value, result_item.sample_count,
                           result_item.dropped);
                    error_count++;
                end
                else
                begin
                    want = pending_medians.pop_front();
                    if (result_item.median_value !== want.median_value)
                    begin
                        $error("median_value: expected %0d, got %0d",
                               want.median_value, result_item.median_value);
                        error_count++;
                    end
                    if (result_item.sample_count !== want.sample_count)
                    begin
                        $error("sample_count: expected %0d, got %0d",
                               want.sample_count, result_item.sample_count);
                        error_count++;
                    end
                    if (result_item.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %0d, got %0d",
                               want.dropped, result_item.dropped);
                        error_count++;
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                pending_medians = {pending_medians, update_median(sample_item)};
            end
        end
    end

    // one input transfer; called at a rising edge, returns at the edge of acceptance
    // with valid still high, so a back-to-back item keeps it high without a dip
    task automatic send_item(input logic kind, input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_item  <= '{kind: kind, sample_value: value};
        @(posedge clk);
        while (!sample_ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input spread_t spread);
        int v;
        case (spread)
            SPREAD_NARROW: v = int'($urandom_range(8)) - 4;
            SPREAD_EDGES:  v = ($urandom_range(1) == 1) ? 32767 - int'($urandom_range(3))
                                                        : -32768 + int'($urandom_range(3));
            default:       v = int'($urandom_range(65535)) - 32768;
        endcase
        return SAMPLE_W'(v);
    endfunction

    // empty store, field extremes, truncation toward zero, equal samples
    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(KIND_CLEAR, 32767);       // clear on an empty stream
        send_item(KIND_SAMPLE, 32767);
        send_item(KIND_SAMPLE, -32768);     // pair mean of the extremes rounds to 0
        send_item(KIND_SAMPLE, -32768);
        send_item(KIND_SAMPLE, -32768);     // both middles at the negative limit
        send_item(KIND_CLEAR, -32768);
        send_item(KIND_SAMPLE, -3);
        send_item(KIND_SAMPLE, 0);          // -3/2 must give -1, not -2
        send_item(KIND_SAMPLE, 0);
        send_item(KIND_SAMPLE, 0);
        send_item(KIND_CLEAR, 0);
        send_item(KIND_SAMPLE, 5);          // run of equal samples
        send_item(KIND_SAMPLE, 5);
        send_item(KIND_SAMPLE, 5);
        send_item(KIND_SAMPLE, 32767);
        send_item(KIND_SAMPLE, 32767);      // second sample at the positive limit
        send_item(KIND_CLEAR, 21845);
        send_item(KIND_SAMPLE, -1);
        send_item(KIND_SAMPLE, -2);         // odd negative sum
        send_item(KIND_CLEAR, 0);
        send_item(KIND_SAMPLE, 21845);      // alternating bit patterns
        send_item(KIND_SAMPLE, -21846);
        send_item(KIND_CLEAR, -1);
    endtask

    // fill the store in descending order so every insertion shifts the whole
    // chain, then push past capacity to see the dropped flag
    task automatic test_store_full();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(KIND_CLEAR, 0);
        for (int i = 0; i < CAPACITY; i++)
        begin
            send_item(KIND_SAMPLE, SAMPLE_W'(30000 - i * 900));
        end
        send_item(KIND_SAMPLE, -32768);
        send_item(KIND_SAMPLE, 32767);
        send_item(KIND_SAMPLE, 0);
        send_item(KIND_CLEAR, 0);
        send_item(KIND_SAMPLE, 7);          // store usable again after overflow
    endtask

    // streams opened by a clear, with random length and value spread; some run past
    // capacity, a few are cut short by a stray clear
    task automatic run_streams(input int item_budget);
        int      sent;
        int      run_len;
        spread_t spread;
        sent = 0;
        while (sent < item_budget)
        begin
            send_item(KIND_CLEAR, SAMPLE_W'($urandom));
            sent++;
            if ($urandom_range(3) == 0)
            begin
                run_len = $urandom_range(CAPACITY, CAPACITY + 16);
            end
            else
            begin
                run_len = $urandom_range(1, 40);
            end
            spread = spread_t'($urandom_range(2));
            repeat (run_len)
            begin
                if ($urandom_range(99) < 3)
                begin
                    send_item(KIND_CLEAR, SAMPLE_W'($urandom));
                end
                else
                begin
                    send_item(KIND_SAMPLE, pick_sample(spread));
                end
                sent++;
            end
        end
    endtask

    task automatic test_streams_no_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_streams(390);
    endtask

    task automatic test_streams_sender_idle();
        sender_idle_pct    = 52;
        receiver_stall_pct = 0;
        run_streams(390);
    endtask

    task automatic test_streams_receiver_stall();
        sender_idle_pct    = 0;
        receiver_stall_pct = 52;
        run_streams(390);
    endtask

    task automatic test_streams_both_idle();
        sender_idle_pct    = 12;
        receiver_stall_pct = 12;
        run_streams(390);
    endtask

    // let every owed result arrive, then a few more cycles to catch extras
    task automatic drain_results();
        int waited;
        sample_valid       <= 1'b0;
        receiver_stall_pct = 0;
        waited             = 0;
        while (pending_medians.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_medians.size() != 0)
        begin
            $error("%0d expected results never transferred", pending_medians.size());
            error_count++;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_full();
        test_streams_no_idle();
        test_streams_sender_idle();
        test_streams_receiver_stall();
        test_streams_both_idle();
        drain_results();
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
